/* sv/hrt_pkg.sv */
// ============================================================================
// hrt_pkg: shared types and constants for the HTTP request head tokenizer
// Holds the parser phase encoding, the role and error codes, the result
// item layout and small helper functions used by the tokenizer modules.
// ============================================================================
package hrt_pkg;

  // Bytes that steer the parser.
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Depth of the result queue and its pointer width.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Parser phase, one-hot.
  typedef enum logic [7:0] {
    PH_METHOD  = 8'b0000_0001,
    PH_URL     = 8'b0000_0010,
    PH_VERSION = 8'b0000_0100,
    PH_LINE    = 8'b0000_1000,
    PH_NAME    = 8'b0001_0000,
    PH_SKIP    = 8'b0010_0000,
    PH_VALUE   = 8'b0100_0000,
    PH_BODY    = 8'b1000_0000
  } ph_t;

  typedef enum logic [2:0] {
    ROLE_METHOD  = 3'd0,
    ROLE_URL     = 3'd1,
    ROLE_VERSION = 3'd2,
    ROLE_NAME    = 3'd3,
    ROLE_VALUE   = 3'd4,
    ROLE_DELIM   = 3'd5,
    ROLE_BODY    = 3'd6
  } role_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NO_METHOD  = 3'd1,
    ERR_NO_URL     = 3'd2,
    ERR_NO_VERSION = 3'd3,
    ERR_NO_COLON   = 3'd4,
    ERR_NO_VALUE   = 3'd5
  } err_t;

  typedef struct packed {
    logic [7:0] byte_out;
    role_t      role;
    logic [5:0] header_number;
    logic       field_start;
    logic       head_done;
    err_t       error_code;
    logic       last_of_run;
  } res_t;

  // Results produced by one committed input item.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic role_t phase_role(input ph_t ph);
    role_t r;
    case (ph)
      PH_METHOD:         r = ROLE_METHOD;
      PH_URL:            r = ROLE_URL;
      PH_VERSION:        r = ROLE_VERSION;
      PH_LINE, PH_NAME:  r = ROLE_NAME;
      PH_SKIP, PH_VALUE: r = ROLE_VALUE;
      default:           r = ROLE_BODY;
    endcase
    return r;
  endfunction

  function automatic err_t phase_err(input ph_t ph);
    err_t e;
    case (ph)
      PH_METHOD:         e = ERR_NO_METHOD;
      PH_URL:            e = ERR_NO_URL;
      PH_VERSION:        e = ERR_NO_VERSION;
      PH_LINE, PH_NAME:  e = ERR_NO_COLON;
      PH_SKIP, PH_VALUE: e = ERR_NO_VALUE;
      default:           e = ERR_NONE;
    endcase
    return e;
  endfunction

  function automatic res_t mk_res(input logic [7:0] b, input role_t role,
                                  input logic [5:0] hn, input logic fs,
                                  input logic hd);
    res_t r;
    r.byte_out      = b;
    r.role          = role;
    r.header_number = hn;
    r.field_start   = fs;
    r.head_done     = hd;
    r.error_code    = ERR_NONE;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

endpackage

/* sv/hrt_step.sv */
// ============================================================================
// hrt_step: input register, parser state and byte classification
// Registers one input item, classifies it against the parser state and
// commits the state update when the result queue has room for two results.
// ============================================================================
module hrt_step #(
  parameter int MAX_HEADERS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_byte,
  input  logic          in_first,
  input  logic          in_last,
  input  logic          space_ok,
  output hrt_pkg::push_t push
);

  localparam logic [5:0] HDR_CAP =
    6'((MAX_HEADERS - 1 > 63) ? 63 : (MAX_HEADERS - 1));

  logic          vld_r;
  logic [7:0]    byte_r;
  logic          first_r;
  logic          last_r;

  hrt_pkg::ph_t  ph_r;
  logic          hcr_r;
  logic [5:0]    hc_r;
  logic          inf_r;

  hrt_pkg::ph_t  ph;
  logic          hcr;
  logic [5:0]    hc;
  logic          inf;
  logic [1:0]    n;
  logic          hd;
  hrt_pkg::res_t res [2];
  logic          commit;

  assign commit    = vld_r && space_ok;
  assign in_tready = !vld_r || space_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r  <= in_byte;
      first_r <= in_first;
      last_r  <= in_last;
    end
  end

  always_comb begin
    ph  = first_r ? hrt_pkg::PH_METHOD : ph_r;
    hcr = first_r ? 1'b0 : hcr_r;
    hc  = first_r ? 6'd0 : hc_r;
    inf = first_r ? 1'b0 : inf_r;
    n   = 2'd0;
    hd  = 1'b0;
    res[0] = '0;
    res[1] = '0;

    if (hcr && byte_r == hrt_pkg::CH_LF) begin
      // CR LF: both bytes are delimiters.
      hd  = (ph == hrt_pkg::PH_LINE);
      hcr = 1'b0;
      inf = 1'b0;
      res[0] = hrt_pkg::mk_res(hrt_pkg::CH_CR, hrt_pkg::ROLE_DELIM, hc, 1'b0, 1'b0);
      res[1] = hrt_pkg::mk_res(byte_r, hrt_pkg::ROLE_DELIM, hc, 1'b0, hd);
      n = 2'd2;
      if (ph == hrt_pkg::PH_LINE) begin
        ph = hrt_pkg::PH_BODY;
      end else begin
        if (ph == hrt_pkg::PH_VALUE && hc < HDR_CAP) begin
          hc = hc + 6'd1;
        end
        ph = hrt_pkg::PH_LINE;
      end
    end else begin
      if (hcr) begin
        // The held CR was not part of a line end: release it as content.
        hcr = 1'b0;
        if (ph == hrt_pkg::PH_LINE) begin
          ph  = hrt_pkg::PH_NAME;
          inf = 1'b0;
        end
        res[0] = hrt_pkg::mk_res(hrt_pkg::CH_CR, hrt_pkg::phase_role(ph), hc, !inf, 1'b0);
        inf = 1'b1;
        n = 2'd1;
      end
      case (ph)
        hrt_pkg::PH_METHOD, hrt_pkg::PH_URL: begin
          if (byte_r == hrt_pkg::CH_SP) begin
            res[n[0]] = hrt_pkg::mk_res(byte_r, hrt_pkg::ROLE_DELIM, hc, 1'b0, 1'b0);
            inf = 1'b0;
            ph  = (ph == hrt_pkg::PH_METHOD) ? hrt_pkg::PH_URL : hrt_pkg::PH_VERSION;
          end else begin
            res[n[0]] = hrt_pkg::mk_res(byte_r, hrt_pkg::phase_role(ph), hc, !inf, 1'b0);
            inf = 1'b1;
          end
          n = n + 2'd1;
        end
        hrt_pkg::PH_VERSION, hrt_pkg::PH_VALUE: begin
          if (byte_r == hrt_pkg::CH_CR) begin
            hcr = 1'b1;
          end else begin
            res[n[0]] = hrt_pkg::mk_res(byte_r, hrt_pkg::phase_role(ph), hc, !inf, 1'b0);
            inf = 1'b1;
            n = n + 2'd1;
          end
        end
        hrt_pkg::PH_LINE, hrt_pkg::PH_NAME: begin
          if (ph == hrt_pkg::PH_LINE && byte_r == hrt_pkg::CH_CR) begin
            hcr = 1'b1;
          end else begin
            ph = hrt_pkg::PH_NAME;
            if (byte_r == hrt_pkg::CH_COLON) begin
              res[n[0]] = hrt_pkg::mk_res(byte_r, hrt_pkg::ROLE_DELIM, hc, 1'b0, 1'b0);
              inf = 1'b0;
              ph  = hrt_pkg::PH_SKIP;
            end else begin
              res[n[0]] = hrt_pkg::mk_res(byte_r, hrt_pkg::ROLE_NAME, hc, !inf, 1'b0);
              inf = 1'b1;
            end
            n = n + 2'd1;
          end
        end
        hrt_pkg::PH_SKIP: begin
          res[n[0]] = hrt_pkg::mk_res(byte_r, hrt_pkg::ROLE_DELIM, hc, 1'b0, 1'b0);
          inf = 1'b0;
          ph  = hrt_pkg::PH_VALUE;
          n = n + 2'd1;
        end
        default: begin
          res[n[0]] = hrt_pkg::mk_res(byte_r, hrt_pkg::ROLE_BODY, hc, !inf, 1'b0);
          inf = 1'b1;
          n = n + 2'd1;
        end
      endcase
    end

    if (last_r) begin
      if (hcr) begin
        hcr = 1'b0;
        if (ph == hrt_pkg::PH_LINE) begin
          ph  = hrt_pkg::PH_NAME;
          inf = 1'b0;
        end
        res[n[0]] = hrt_pkg::mk_res(hrt_pkg::CH_CR, hrt_pkg::phase_role(ph), hc, !inf,
                                    1'b0);
        n = n + 2'd1;
      end
      if (n != 2'd0) begin
        res[~n[0]].error_code = hrt_pkg::phase_err(ph);
      end
      ph  = hrt_pkg::PH_METHOD;
      hcr = 1'b0;
      hc  = 6'd0;
      inf = 1'b0;
    end

    if (n != 2'd0) begin
      res[~n[0]].last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= hrt_pkg::PH_METHOD;
      hcr_r <= 1'b0;
      hc_r  <= 6'd0;
      inf_r <= 1'b0;
    end else if (commit) begin
      ph_r  <= ph;
      hcr_r <= hcr;
      hc_r  <= hc;
      inf_r <= inf;
    end
  end

  assign push.cnt = commit ? n : 2'd0;
  assign push.r0  = res[0];
  assign push.r1  = res[1];

endmodule

/* sv/hrt_outq.sv */
// ============================================================================
// hrt_outq: result queue
// Four-entry queue that takes up to two results per cycle and hands out one
// result per cycle on the output channel while the output is ready.
// ============================================================================
module hrt_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  hrt_pkg::push_t push,
  output logic           space_ok,
  output logic           out_valid,
  input  logic           out_ready,
  output hrt_pkg::res_t  out_res
);

  hrt_pkg::res_t                mem_r [hrt_pkg::QDEPTH];
  logic [hrt_pkg::QPTR_W-1:0]   wptr_r;
  logic [hrt_pkg::QPTR_W-1:0]   wptr_nxt;
  logic [hrt_pkg::QPTR_W-1:0]   rptr_r;
  logic [hrt_pkg::QCNT_W-1:0]   cnt_r;
  logic [hrt_pkg::QCNT_W-1:0]   cnt_nxt;
  logic                         pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign space_ok  = (cnt_r <= hrt_pkg::QCNT_W'(hrt_pkg::QDEPTH - 2));
  assign out_res   = mem_r[rptr_r];

  assign wptr_nxt = wptr_r + hrt_pkg::QPTR_W'(push.cnt);
  assign cnt_nxt  = cnt_r + hrt_pkg::QCNT_W'(push.cnt) - hrt_pkg::QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wptr_r + hrt_pkg::QPTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      cnt_r  <= cnt_nxt;
      if (pop) begin
        rptr_r <= rptr_r + hrt_pkg::QPTR_W'(1);
      end
    end
  end

endmodule

/* sv/http_request_head_tokenizer.sv */
// ============================================================================
// http_request_head_tokenizer: byte-wise HTTP/1.1 request head tokenizer
// Tags each request byte with its role and header index, marks field starts,
// the end of the head and early-end errors.
// ============================================================================
// The block takes one request byte per item and returns one or two result
// items per byte, each tagging a byte with its role (method, URL, version,
// header name, header value, delimiter or body), the current header index,
// a field-start mark, a head-done mark on the LF of the blank line and, on
// the last result of a final byte, the error code of an unfinished head.
// A CR that may open a line end is held and, unless it is the final byte,
// produces no result until the next byte shows whether it is a CR LF; that
// next byte then yields up to two results. An input item is registered,
// classified by a single pass of logic and its results are written into a
// four-entry result queue; a new item is taken every cycle as long as the
// queue holds at most two results, so while the output is ready the block
// sustains one item per cycle on traffic without CR LF pairs and drains the
// extra result of a CR LF through the queue.
module http_request_head_tokenizer #(
  parameter int MAX_HEADERS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] first_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] byte_out, [13:8] header_number,
                                  // [14] field_start, [15] head_done,
                                  // [18:16] error_code, [23:19] zero
  output logic [2:0]  out_tuser,  // [2:0] role
  output logic        out_tlast   // last_of_run
);

  hrt_pkg::push_t push;
  hrt_pkg::res_t  res;
  logic           space_ok;

  // Input register, parser state and classification.
  hrt_step #(
    .MAX_HEADERS(MAX_HEADERS)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_byte  (in_tdata),
    .in_first (in_tuser),
    .in_last  (in_tlast),
    .space_ok (space_ok),
    .push     (push)
  );

  // Result queue decouples the two results of a CR LF from the output rate.
  hrt_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (space_ok),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  assign out_tdata = {5'd0, res.error_code, res.head_done, res.field_start,
                      res.header_number, res.byte_out};
  assign out_tuser = res.role;
  assign out_tlast = res.last_of_run;

endmodule
